// ----- rtl/ttb_pkg.sv -----
// Shared types, widths and constants of the triangle tangent basis unit.
// No dependencies; every other file of the block imports this package.
package ttb_pkg;

  localparam int unsigned FRAC_BITS = 16;                 // fraction bits of Q format
  localparam int unsigned DATA_W    = 32;                 // field width
  localparam int unsigned DELTA_W   = DATA_W + 1;         // exact difference of two fields
  localparam int unsigned PROD_W    = 2 * DELTA_W;        // product of two deltas
  localparam int unsigned ACC_W     = PROD_W + 1;         // a*b - c*d, signed
  localparam int unsigned MAG_W     = ACC_W - 1;          // magnitude of a cross term
  localparam int unsigned REM_W     = MAG_W + 1;          // partial remainder
  localparam int unsigned QUO_W     = DATA_W;             // quotient bits developed
  localparam int unsigned XW        = MAG_W + FRAC_BITS;  // scaled dividend
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W);
  localparam int unsigned JOB_W     = 3;                  // cross-product index 0..6
  localparam int unsigned NUM_VEC   = 6;                  // tangent xyz, bitangent xyz

  localparam logic [1:0] SLOT_LAST = 2'd2;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] tex_u;
    logic signed [DATA_W-1:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] tangent_x;
    logic signed [DATA_W-1:0] tangent_y;
    logic signed [DATA_W-1:0] tangent_z;
    logic signed [DATA_W-1:0] bitangent_x;
    logic signed [DATA_W-1:0] bitangent_y;
    logic signed [DATA_W-1:0] bitangent_z;
    logic [1:0]               vertex_slot;
    logic                     degenerate;
    logic                     last_of_triangle;
  } res_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } ttb_state_e;

endpackage

// ----- rtl/ttb_vtx_if.sv -----
// Vertex input channel: valid/ready handshake with a vertex payload.
// Depends on ttb_pkg for the payload type.
interface ttb_vtx_if import ttb_pkg::*; ();
  logic valid;
  logic ready;
  vtx_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ttb_res_if.sv -----
// Result output channel: valid/ready handshake with a tangent basis payload.
// Depends on ttb_pkg for the payload type.
interface ttb_res_if import ttb_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ttb_div.sv -----
// Iterative signed divider: (num * 2^FRAC_BITS) / den, truncated, saturated to 32 bits.
// Restoring division, one quotient bit per cycle. Depends on ttb_pkg.
module ttb_div import ttb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_ctrl_t               ctrl_i,
  input  logic signed [ACC_W-1:0] num_i,
  input  logic signed [ACC_W-1:0] den_i,
  output div_stat_t               stat_o,
  output logic signed [QUO_W-1:0] quo_o
);

  div_state_e state_q, state_d;

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [REM_W-1:0]     rem_q;
  logic [MAG_W-1:0]     den_q;
  logic [QUO_W-1:0]     low_q;
  logic [QUO_W-1:0]     quo_q;
  logic                 neg_q;
  logic                 sat_q;

  logic [ACC_W-1:0] num_abs, den_abs;
  logic [XW-1:0]    xw;
  logic [REM_W-1:0] rem0, trial, den_ext;
  logic             sat0, ge;

  // Magnitudes; a cross term never reaches 2^(MAG_W), so the top bit drops.
  assign num_abs = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  assign den_abs = den_i[ACC_W-1] ? ACC_W'(-den_i) : ACC_W'(den_i);
  assign xw      = {num_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
  assign rem0    = REM_W'(xw[XW-1:QUO_W]);
  // The quotient needs more than QUO_W bits exactly when the upper dividend reaches den.
  assign sat0    = rem0 >= {1'b0, den_abs[MAG_W-1:0]};

  assign den_ext = {1'b0, den_q};
  assign trial   = {rem_q[REM_W-2:0], low_q[QUO_W-1]};
  assign ge      = trial >= den_ext;

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: if (ctrl_i.start) begin
        state_d = sat0 ? DIV_DONE : DIV_RUN;
      end
      DIV_RUN: if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
        state_d = DIV_DONE;
      end
      DIV_DONE: state_d = DIV_IDLE;
      default: state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    stat_o = '0;
    case (state_q)
      DIV_RUN:  stat_o.busy = 1'b1;
      DIV_DONE: begin
        stat_o.busy = 1'b1;
        stat_o.done = 1'b1;
      end
      default: stat_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && ctrl_i.start) begin
      rem_q <= rem0;
      den_q <= den_abs[MAG_W-1:0];
      low_q <= xw[QUO_W-1:0];
      neg_q <= num_i[ACC_W-1] ^ den_i[ACC_W-1];
      sat_q <= sat0;
      quo_q <= '0;
    end else if (state_q == DIV_RUN) begin
      rem_q <= ge ? REM_W'(trial - den_ext) : trial;
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  always_comb begin
    if (neg_q) begin
      if (sat_q || quo_q > SAT_MIN) begin
        quo_o = SAT_MIN;
      end else begin
        quo_o = QUO_W'(-quo_q);
      end
    end else begin
      if (sat_q || quo_q[QUO_W-1]) begin
        quo_o = SAT_MAX;
      end else begin
        quo_o = quo_q;
      end
    end
  end

endmodule

// ----- rtl/triangle_tangent_basis_unit.sv -----
// Sequence: vertices 0 and 1 of a triangle are stored and give no result.
// After vertex 2 is accepted the determinant is formed; when it is zero the results are
// presented without any divide, else each of the six components takes two products, a
// subtract, a start state and a divide, which ends early when the quotient saturates.
// No vertex is taken until the three results of the triangle have been transferred.
// Throughput is set by the divider, which develops one quotient bit per cycle.
// Reset: rst_ni clears the vertex count and the sequencers; held vertices are not cleared.

// Top level of the triangle tangent basis unit.
// Depends on ttb_pkg, ttb_vtx_if, ttb_res_if and ttb_div.
module triangle_tangent_basis_unit import ttb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttb_vtx_if.sink     vtx_i,
  ttb_res_if.source   res_o
);

  // Sequencer and control state.
  ttb_state_e       state_q, state_d;
  logic [1:0]       cnt_q;
  logic [JOB_W-1:0] job_q;
  logic [1:0]       slot_q;

  // Held vertices 0 and 1.
  logic signed [DATA_W-1:0] pos_q [2][3];
  logic signed [DATA_W-1:0] tex_q [2][2];

  // Edge and texture-coordinate deltas of the current triangle.
  logic signed [DELTA_W-1:0] dp1_q [3];
  logic signed [DELTA_W-1:0] dp2_q [3];
  logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;

  // Shared multiplier, accumulator and result registers.
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, num_q, det_q;
  logic signed [DATA_W-1:0] res_q [NUM_VEC];
  logic                     degen_q;

  logic                      in_xfer, out_xfer, last_vtx;
  logic signed [DELTA_W-1:0] a0, b0, a1, b1, op_a, op_b;
  logic signed [PROD_W-1:0]  mul_w;
  logic signed [ACC_W-1:0]   cross_w;
  logic [1:0]                tan_c, bit_c;
  logic [JOB_W-1:0]          res_idx;
  logic signed [DATA_W-1:0]  in_pos [3];
  logic signed [DATA_W-1:0]  quo;
  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;

  assign in_xfer  = vtx_i.valid && vtx_i.ready;
  assign out_xfer = res_o.valid && res_o.ready;
  // The count never reaches three, so anything but 0 or 1 means the closing vertex.
  assign last_vtx = cnt_q[1];

  assign in_pos[0] = vtx_i.data.pos_x;
  assign in_pos[1] = vtx_i.data.pos_y;
  assign in_pos[2] = vtx_i.data.pos_z;

  // Cross-product jobs: job 0 is the UV determinant, jobs 1 to 3 the tangent
  // numerators and jobs 4 to 6 the bitangent numerators, each a*b - c*d.
  assign tan_c   = 2'(job_q - JOB_W'(1));
  assign bit_c   = 2'(job_q - JOB_W'(4));
  assign res_idx = JOB_W'(job_q - JOB_W'(1));

  always_comb begin
    a0 = '0;
    b0 = '0;
    a1 = '0;
    b1 = '0;
    case (job_q)
      3'd0: begin
        a0 = du1_q; b0 = dv2_q; a1 = dv1_q; b1 = du2_q;
      end
      3'd1, 3'd2, 3'd3: begin
        a0 = dp1_q[tan_c]; b0 = dv2_q; a1 = dp2_q[tan_c]; b1 = dv1_q;
      end
      3'd4, 3'd5, 3'd6: begin
        a0 = dp2_q[bit_c]; b0 = du1_q; a1 = dp1_q[bit_c]; b1 = du2_q;
      end
      default: begin
        a0 = '0; b0 = '0; a1 = '0; b1 = '0;
      end
    endcase
  end

  // The first product is formed in ST_MUL0, the second in ST_MUL1.
  assign op_a    = (state_q == ST_MUL0) ? a0 : a1;
  assign op_b    = (state_q == ST_MUL0) ? b0 : b1;
  assign mul_w   = op_a * op_b;
  assign cross_w = ACC_W'(acc_q - ACC_W'(prod_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer && last_vtx) begin
        state_d = ST_MUL0;
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_ACC;
      ST_ACC: begin
        if (job_q != '0) begin
          state_d = ST_DSTART;
        end else if (cross_w == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL0;
        end
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: if (div_stat.done) begin
        state_d = (job_q == JOB_W'(NUM_VEC)) ? ST_OUT : ST_MUL0;
      end
      ST_OUT: if (out_xfer && slot_q == SLOT_LAST) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and unit control outputs.
  always_comb begin
    vtx_i.ready    = 1'b0;
    res_o.valid    = 1'b0;
    div_ctrl.start = 1'b0;
    case (state_q)
      ST_IDLE:   vtx_i.ready    = 1'b1;
      ST_DSTART: div_ctrl.start = 1'b1;
      ST_OUT:    res_o.valid    = 1'b1;
      default: begin
        vtx_i.ready    = 1'b0;
        res_o.valid    = 1'b0;
        div_ctrl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      job_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        cnt_q <= last_vtx ? 2'd0 : cnt_q + 2'd1;
        job_q <= '0;
      end
      if (state_q == ST_ACC && job_q == '0) begin
        job_q <= JOB_W'(1);
      end
      if (state_q == ST_DWAIT && div_stat.done) begin
        job_q <= job_q + JOB_W'(1);
      end
      if (state_q != ST_OUT) begin
        slot_q <= '0;
      end else if (out_xfer) begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  // Datapath registers; none of them needs a reset value.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (!last_vtx) begin
        pos_q[cnt_q[0]][0] <= vtx_i.data.pos_x;
        pos_q[cnt_q[0]][1] <= vtx_i.data.pos_y;
        pos_q[cnt_q[0]][2] <= vtx_i.data.pos_z;
        tex_q[cnt_q[0]][0] <= vtx_i.data.tex_u;
        tex_q[cnt_q[0]][1] <= vtx_i.data.tex_v;
      end else begin
        for (int c = 0; c < 3; c++) begin
          dp1_q[c] <= DELTA_W'(pos_q[1][c]) - DELTA_W'(pos_q[0][c]);
          dp2_q[c] <= DELTA_W'(in_pos[c]) - DELTA_W'(pos_q[0][c]);
        end
        du1_q <= DELTA_W'(tex_q[1][0]) - DELTA_W'(tex_q[0][0]);
        dv1_q <= DELTA_W'(tex_q[1][1]) - DELTA_W'(tex_q[0][1]);
        du2_q <= DELTA_W'(vtx_i.data.tex_u) - DELTA_W'(tex_q[0][0]);
        dv2_q <= DELTA_W'(vtx_i.data.tex_v) - DELTA_W'(tex_q[0][1]);
      end
    end
    if (state_q == ST_MUL0 || state_q == ST_MUL1) begin
      prod_q <= mul_w;
    end
    if (state_q == ST_MUL1) begin
      acc_q <= ACC_W'(prod_q);
    end
    if (state_q == ST_ACC) begin
      num_q <= cross_w;
      if (job_q == '0) begin
        det_q   <= cross_w;
        degen_q <= (cross_w == '0);
      end
    end
    if (state_q == ST_DWAIT && div_stat.done) begin
      res_q[res_idx] <= quo;
    end
  end

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_q),
    .den_i  (det_q),
    .stat_o (div_stat),
    .quo_o  (quo)
  );

  // A degenerate triangle shows zero vectors; the result registers then hold stale data.
  assign res_o.data.tangent_x        = degen_q ? '0 : res_q[0];
  assign res_o.data.tangent_y        = degen_q ? '0 : res_q[1];
  assign res_o.data.tangent_z        = degen_q ? '0 : res_q[2];
  assign res_o.data.bitangent_x      = degen_q ? '0 : res_q[3];
  assign res_o.data.bitangent_y      = degen_q ? '0 : res_q[4];
  assign res_o.data.bitangent_z      = degen_q ? '0 : res_q[5];
  assign res_o.data.vertex_slot      = slot_q;
  assign res_o.data.degenerate       = degen_q;
  assign res_o.data.last_of_triangle = (slot_q == SLOT_LAST);

  // The block never takes a vertex while results of the last triangle wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vtx_i.ready && res_o.valid))
    else $error("vertex accepted while results are pending");

  // Closing vertex starts the computation and drops ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_vtx) |=> (!vtx_i.ready && cnt_q == 2'd0))
    else $error("closing vertex did not start the computation");

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The transfer of the third result returns the block to accepting vertices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && slot_q == SLOT_LAST) |=> (vtx_i.ready && !res_o.valid))
    else $error("block did not return to idle after the third result");

endmodule
